// File: hdl/tdpt_pkg.sv
package tdpt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic   done;
    value_t quo;
    value_t rem;
  } div_res_t;

endpackage

// File: hdl/tdpt_divider.sv
module tdpt_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tdpt_pkg::value_t   dividend,
  input  tdpt_pkg::value_t   divisor,
  output tdpt_pkg::div_res_t res
);
  import tdpt_pkg::*;

  logic                 busy;
  logic                 done;
  count_t               count;
  value_t               rem;
  value_t               quo;
  value_t               dvs;
  logic [VALUE_WIDTH:0] trial;
  logic [VALUE_WIDTH:0] diff;

  assign trial = {rem, quo[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem   <= '0;
      dvs   <= divisor;
      count <= count_t'(VALUE_WIDTH - 1);
    end else if (busy) begin
      if (!diff[VALUE_WIDTH]) begin
        rem <= diff[VALUE_WIDTH-1:0];
        quo <= {quo[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial[VALUE_WIDTH-1:0];
        quo <= {quo[VALUE_WIDTH-2:0], 1'b0};
      end
      count <= count - count_t'(1);
    end
  end

  assign res.done = done;
  assign res.quo  = quo;
  assign res.rem  = rem;

endmodule

// File: hdl/trial_division_prime_test.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  candidate_value [VALUE_WIDTH]
// out      output     out_valid / out_stall prime_flag [1]
//
// 0, 1, 2 and even candidates: no division; result loaded from S_EMIT.
// Odd candidates: one division per trial divisor (serial restoring
// divider, one quotient bit per cycle), from 3 up to the first divisor that
// divides n or whose square exceeds n; result then loaded from S_EMIT.
// One candidate in flight; in_stall is high from acceptance until its result
// is loaded into the output register, which holds under out_stall; reset clears control only.
module trial_division_prime_test (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tdpt_pkg::value_t candidate_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             prime_flag
);
  import tdpt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t   state;
  value_t   n;
  value_t   d;
  logic     div_start;
  logic     result_flag;
  logic     out_free;
  div_res_t res;

  tdpt_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (d),
    .res      (res)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state == S_EMIT) || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            n <= candidate_value;
            d <= value_t'(3);
            priority if (candidate_value[VALUE_WIDTH-1:1] == '0) begin
              result_flag <= 1'b0;
              div_start   <= 1'b0;
              state       <= S_EMIT;
            end else if (candidate_value == value_t'(2)) begin
              result_flag <= 1'b1;
              div_start   <= 1'b0;
              state       <= S_EMIT;
            end else if (!candidate_value[0]) begin
              result_flag <= 1'b0;
              div_start   <= 1'b0;
              state       <= S_EMIT;
            end else begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end else begin
            div_start <= 1'b0;
          end
        end
        S_DIV: begin
          if (res.done) begin
            priority if (d > res.quo) begin
              result_flag <= 1'b1;
              div_start   <= 1'b0;
              state       <= S_EMIT;
            end else if (res.rem == '0) begin
              result_flag <= 1'b0;
              div_start   <= 1'b0;
              state       <= S_EMIT;
            end else begin
              d         <= d + value_t'(2);
              div_start <= 1'b1;
            end
          end else begin
            div_start <= 1'b0;
          end
        end
        S_EMIT: begin
          div_start <= 1'b0;
          if (out_free) begin
            prime_flag <= result_flag;
            state      <= S_IDLE;
          end
        end
        default: begin
          div_start <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    res.done |-> state == S_DIV)
    else $error("divider finished outside the trial loop");

  a_start_not_done: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !res.done)
    else $error("divider reported done right after start");

  a_odd_divisor: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> d[0])
    else $error("trial divisor is even");

  a_bound_prime: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && res.done && d > res.quo) |=> (state == S_EMIT && result_flag))
    else $error("divisor past bound did not report prime");

endmodule
